>>> design/scrolling_led_matrix_text_buffer_unit_macros.svh
// Assertion macros shared by the frame buffer checker.
`ifndef SCROLLING_LED_MATRIX_TEXT_BUFFER_UNIT_MACROS_SVH
`define SCROLLING_LED_MATRIX_TEXT_BUFFER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define SLMTB_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define SLMTB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/slmtb_pkg.sv
// Package: action codes, font ROM and glyph lookup for the LED matrix frame buffer.
`default_nettype none

package slmtb_pkg;

   localparam int CELLS_DEFAULT = 4;
   localparam int FONT_GLYPHS   = 103;
   localparam int GLYPH_W       = $clog2(FONT_GLYPHS);

   localparam logic [2:0] ACT_CLEAR   = 3'd0;
   localparam logic [2:0] ACT_SHL     = 3'd1;
   localparam logic [2:0] ACT_SHR     = 3'd2;
   localparam logic [2:0] ACT_GCOL    = 3'd3;
   localparam logic [2:0] ACT_GCELL   = 3'd4;
   localparam logic [2:0] ACT_OR      = 3'd5;
   localparam logic [2:0] ACT_DISPLAY = 3'd6;

   localparam logic [GLYPH_W-1:0] GLYPH_STAR = GLYPH_W'(10);

   localparam logic [7:0] FONT_ROM [FONT_GLYPHS][8] = '{
      '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
      '{8'h01,8'h01,8'h01,8'h01,8'h01,8'h00,8'h01,8'h00},
      '{8'h05,8'h05,8'h0a,8'h00,8'h00,8'h00,8'h00,8'h00},
      '{8'h00,8'h05,8'h1f,8'h0a,8'h1f,8'h14,8'h00,8'h00},
      '{8'h0f,8'h14,8'h14,8'h0e,8'h05,8'h05,8'h1e,8'h00},
      '{8'h00,8'h19,8'h1a,8'h04,8'h0b,8'h13,8'h00,8'h00},
      '{8'h0c,8'h12,8'h12,8'h0d,8'h12,8'h12,8'h0d,8'h00},
      '{8'h01,8'h01,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
      '{8'h01,8'h02,8'h02,8'h02,8'h02,8'h02,8'h01,8'h00},
      '{8'h02,8'h01,8'h01,8'h01,8'h01,8'h01,8'h02,8'h00},
      '{8'h00,8'h15,8'h0e,8'h1f,8'h0e,8'h15,8'h00,8'h00},
      '{8'h00,8'h04,8'h04,8'h1f,8'h04,8'h04,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h01,8'h02},
      '{8'h00,8'h00,8'h00,8'h07,8'h00,8'h00,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h01,8'h00},
      '{8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h00,8'h00},
      '{8'h0e,8'h11,8'h13,8'h15,8'h19,8'h11,8'h0e,8'h00},
      '{8'h02,8'h06,8'h02,8'h02,8'h02,8'h02,8'h07,8'h00},
      '{8'h0e,8'h11,8'h02,8'h04,8'h08,8'h10,8'h1f,8'h00},
      '{8'h0e,8'h11,8'h01,8'h06,8'h01,8'h11,8'h0e,8'h00},
      '{8'h02,8'h06,8'h0a,8'h12,8'h1f,8'h02,8'h02,8'h00},
      '{8'h1f,8'h10,8'h10,8'h1e,8'h01,8'h01,8'h1e,8'h00},
      '{8'h0e,8'h11,8'h10,8'h1e,8'h11,8'h11,8'h0e,8'h00},
      '{8'h1f,8'h11,8'h02,8'h04,8'h08,8'h08,8'h08,8'h00},
      '{8'h0e,8'h11,8'h11,8'h0e,8'h11,8'h11,8'h0e,8'h00},
      '{8'h0e,8'h11,8'h11,8'h0f,8'h01,8'h11,8'h0e,8'h00},
      '{8'h00,8'h00,8'h01,8'h00,8'h00,8'h00,8'h01,8'h00},
      '{8'h00,8'h00,8'h01,8'h00,8'h00,8'h01,8'h02,8'h00},
      '{8'h00,8'h01,8'h02,8'h04,8'h02,8'h01,8'h00,8'h00},
      '{8'h00,8'h00,8'h1f,8'h00,8'h1f,8'h00,8'h00,8'h00},
      '{8'h00,8'h04,8'h02,8'h01,8'h02,8'h04,8'h00,8'h00},
      '{8'h0e,8'h11,8'h01,8'h02,8'h04,8'h00,8'h04,8'h00},
      '{8'h0e,8'h11,8'h17,8'h15,8'h17,8'h08,8'h07,8'h00},
      '{8'h0e,8'h11,8'h11,8'h1f,8'h11,8'h11,8'h11,8'h00},
      '{8'h1e,8'h11,8'h11,8'h1e,8'h11,8'h11,8'h1e,8'h00},
      '{8'h0f,8'h10,8'h10,8'h10,8'h10,8'h10,8'h0f,8'h00},
      '{8'h1e,8'h11,8'h11,8'h11,8'h11,8'h11,8'h1e,8'h00},
      '{8'h1f,8'h10,8'h10,8'h1e,8'h10,8'h10,8'h1f,8'h00},
      '{8'h1f,8'h10,8'h10,8'h1f,8'h10,8'h10,8'h10,8'h00},
      '{8'h0e,8'h10,8'h10,8'h13,8'h11,8'h11,8'h0e,8'h00},
      '{8'h11,8'h11,8'h11,8'h1f,8'h11,8'h11,8'h11,8'h00},
      '{8'h07,8'h02,8'h02,8'h02,8'h02,8'h02,8'h07,8'h00},
      '{8'h07,8'h01,8'h01,8'h01,8'h01,8'h11,8'h0e,8'h00},
      '{8'h11,8'h12,8'h14,8'h18,8'h14,8'h12,8'h11,8'h00},
      '{8'h10,8'h10,8'h10,8'h10,8'h10,8'h10,8'h1f,8'h00},
      '{8'h11,8'h11,8'h1b,8'h15,8'h11,8'h11,8'h11,8'h00},
      '{8'h11,8'h11,8'h19,8'h15,8'h13,8'h11,8'h11,8'h00},
      '{8'h0e,8'h11,8'h11,8'h11,8'h11,8'h11,8'h0e,8'h00},
      '{8'h1e,8'h11,8'h11,8'h1e,8'h10,8'h10,8'h10,8'h00},
      '{8'h0e,8'h11,8'h11,8'h11,8'h11,8'h12,8'h0d,8'h00},
      '{8'h1e,8'h11,8'h11,8'h1e,8'h11,8'h11,8'h11,8'h00},
      '{8'h0f,8'h10,8'h10,8'h0e,8'h01,8'h01,8'h1e,8'h00},
      '{8'h1f,8'h04,8'h04,8'h04,8'h04,8'h04,8'h04,8'h00},
      '{8'h11,8'h11,8'h11,8'h11,8'h11,8'h11,8'h0e,8'h00},
      '{8'h11,8'h11,8'h11,8'h0a,8'h0a,8'h04,8'h04,8'h00},
      '{8'h11,8'h11,8'h15,8'h15,8'h15,8'h1b,8'h11,8'h00},
      '{8'h11,8'h11,8'h0a,8'h04,8'h0a,8'h11,8'h11,8'h00},
      '{8'h11,8'h11,8'h0a,8'h04,8'h04,8'h04,8'h04,8'h00},
      '{8'h1f,8'h01,8'h02,8'h04,8'h08,8'h10,8'h1f,8'h00},
      '{8'h00,8'h00,8'h0e,8'h01,8'h0f,8'h11,8'h0f,8'h00},
      '{8'h10,8'h10,8'h1e,8'h11,8'h11,8'h11,8'h1e,8'h00},
      '{8'h00,8'h00,8'h0f,8'h10,8'h10,8'h10,8'h0f,8'h00},
      '{8'h01,8'h01,8'h0f,8'h11,8'h11,8'h11,8'h0f,8'h00},
      '{8'h00,8'h00,8'h0e,8'h11,8'h1f,8'h10,8'h0f,8'h00},
      '{8'h03,8'h04,8'h06,8'h04,8'h04,8'h04,8'h04,8'h00},
      '{8'h00,8'h00,8'h0f,8'h11,8'h11,8'h0f,8'h01,8'h0e},
      '{8'h10,8'h10,8'h1e,8'h11,8'h11,8'h11,8'h11,8'h00},
      '{8'h02,8'h00,8'h06,8'h02,8'h02,8'h02,8'h07,8'h00},
      '{8'h01,8'h00,8'h03,8'h01,8'h01,8'h01,8'h01,8'h06},
      '{8'h10,8'h10,8'h11,8'h12,8'h1c,8'h12,8'h11,8'h00},
      '{8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,8'h01,8'h00},
      '{8'h00,8'h00,8'h1a,8'h15,8'h15,8'h15,8'h15,8'h00},
      '{8'h00,8'h00,8'h16,8'h19,8'h11,8'h11,8'h11,8'h00},
      '{8'h00,8'h00,8'h0e,8'h11,8'h11,8'h11,8'h0e,8'h00},
      '{8'h00,8'h00,8'h1e,8'h11,8'h11,8'h1e,8'h10,8'h10},
      '{8'h00,8'h00,8'h0f,8'h11,8'h11,8'h0f,8'h01,8'h01},
      '{8'h00,8'h00,8'h16,8'h19,8'h10,8'h10,8'h10,8'h00},
      '{8'h00,8'h00,8'h0f,8'h10,8'h0e,8'h01,8'h1e,8'h00},
      '{8'h04,8'h04,8'h0e,8'h04,8'h04,8'h04,8'h03,8'h00},
      '{8'h00,8'h00,8'h11,8'h11,8'h11,8'h13,8'h0d,8'h00},
      '{8'h00,8'h00,8'h11,8'h11,8'h0a,8'h0a,8'h04,8'h00},
      '{8'h00,8'h00,8'h15,8'h15,8'h15,8'h15,8'h0a,8'h00},
      '{8'h00,8'h00,8'h11,8'h0a,8'h04,8'h0a,8'h11,8'h00},
      '{8'h00,8'h00,8'h11,8'h11,8'h11,8'h0f,8'h01,8'h0e},
      '{8'h00,8'h00,8'h1f,8'h02,8'h04,8'h08,8'h1f,8'h00},
      '{8'h02,8'h04,8'h0e,8'h11,8'h1f,8'h11,8'h11,8'h00},
      '{8'h02,8'h04,8'h1f,8'h10,8'h1e,8'h10,8'h1f,8'h00},
      '{8'h01,8'h02,8'h0e,8'h04,8'h04,8'h04,8'h0e,8'h00},
      '{8'h02,8'h04,8'h0e,8'h11,8'h11,8'h11,8'h0e,8'h00},
      '{8'h0a,8'h00,8'h0e,8'h11,8'h11,8'h11,8'h0e,8'h00},
      '{8'h05,8'h0a,8'h0e,8'h11,8'h11,8'h11,8'h0e,8'h00},
      '{8'h02,8'h04,8'h11,8'h11,8'h11,8'h11,8'h0e,8'h00},
      '{8'h0a,8'h00,8'h11,8'h11,8'h11,8'h11,8'h0e,8'h00},
      '{8'h05,8'h0a,8'h11,8'h11,8'h11,8'h11,8'h0e,8'h00},
      '{8'h02,8'h04,8'h0e,8'h01,8'h0f,8'h11,8'h0f,8'h00},
      '{8'h02,8'h04,8'h0e,8'h11,8'h1f,8'h10,8'h0f,8'h00},
      '{8'h01,8'h02,8'h06,8'h02,8'h02,8'h02,8'h07,8'h00},
      '{8'h02,8'h04,8'h00,8'h0e,8'h11,8'h11,8'h0e,8'h00},
      '{8'h00,8'h0a,8'h00,8'h0e,8'h11,8'h11,8'h0e,8'h00},
      '{8'h05,8'h0a,8'h00,8'h0e,8'h11,8'h11,8'h0e,8'h00},
      '{8'h02,8'h04,8'h00,8'h11,8'h11,8'h13,8'h0d,8'h00},
      '{8'h00,8'h0a,8'h00,8'h11,8'h11,8'h13,8'h0d,8'h00},
      '{8'h05,8'h0a,8'h00,8'h11,8'h11,8'h13,8'h0d,8'h00}
   };

   function automatic logic [GLYPH_W-1:0] glyph_index(input logic [7:0] code);
      logic [GLYPH_W-1:0] idx;
      idx = GLYPH_STAR;
      if (code >= 8'h20 && code <= 8'd90) begin
         idx = GLYPH_W'(code - 8'h20);
      end else if (code >= 8'd97 && code <= 8'd122) begin
         idx = GLYPH_W'(code - 8'h26);
      end else begin
         case (code)
            8'd129:  idx = GLYPH_W'(85);
            8'd137:  idx = GLYPH_W'(86);
            8'd141:  idx = GLYPH_W'(87);
            8'd147:  idx = GLYPH_W'(88);
            8'd150:  idx = GLYPH_W'(89);
            8'd144:  idx = GLYPH_W'(90);
            8'd154:  idx = GLYPH_W'(91);
            8'd156:  idx = GLYPH_W'(92);
            8'd176:  idx = GLYPH_W'(93);
            8'd161:  idx = GLYPH_W'(94);
            8'd169:  idx = GLYPH_W'(95);
            8'd173:  idx = GLYPH_W'(96);
            8'd179:  idx = GLYPH_W'(97);
            8'd182:  idx = GLYPH_W'(98);
            8'd145:  idx = GLYPH_W'(99);
            8'd186:  idx = GLYPH_W'(100);
            8'd188:  idx = GLYPH_W'(101);
            8'd177:  idx = GLYPH_W'(102);
            default: idx = GLYPH_STAR;
         endcase
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

>>> design/scrolling_led_matrix_text_buffer_unit.sv
// Top level: scrolling text frame buffer for a chain of 8x8 LED matrices.
//
//   channel | dir | handshake           | payload
//   req     | in  | req_valid/req_stall | action, char_code, glyph_column, glyph_shift,
//           |     |                     | cell_index, row_index, data_byte
//   rsp     | out | rsp_valid/rsp_stall | out_digit, out_cell, out_bits, last_of_frame
//
// One row modifier walks the frame RAM under a small sequencer, one row byte at a time.
// Clear and no-op requests stay in idle; OR byte edits one row; glyph actions walk one cell.
// Shifts and display walk every row of every cell; display rows are read, then held.
// Reset clears the valid bit of every frame entry at once; invalid entries read as zero.
// req_stall is high in reset and from acceptance until the last row; clear/no-op skip it.
`default_nettype none

module scrolling_led_matrix_text_buffer_unit import slmtb_pkg::*; #(
   parameter int CELLS = CELLS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [2:0] req_action,
   input  wire logic [7:0] req_char_code,
   input  wire logic [2:0] req_glyph_column,
   input  wire logic [2:0] req_glyph_shift,
   input  wire logic [2:0] req_cell_index,
   input  wire logic [2:0] req_row_index,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic      [3:0] rsp_out_digit,
   output logic      [2:0] rsp_out_cell,
   output logic      [7:0] rsp_out_bits,
   output logic            rsp_last_of_frame
);

   localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int ADDR_W = CELL_W + 3;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam logic [CELL_W-1:0] CELL_LAST = CELL_W'(CELLS - 1);
   localparam logic [3:0] CELLS_W4 = 4'(CELLS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_MOD  = 2'd2;
   localparam logic [1:0] ST_SEND = 2'd3;

   logic [1:0]         state_ff,     state_in;
   logic [2:0]         act_ff,       act_in;
   logic [GLYPH_W-1:0] gidx_ff,      gidx_in;
   logic [2:0]         gcol_ff,      gcol_in;
   logic [2:0]         gshift_ff,    gshift_in;
   logic [7:0]         data_ff,      data_in;
   logic [CELL_W-1:0]  cell_ff,      cell_in;
   logic [2:0]         row_ff,       row_in;
   logic               carry_ff,     carry_in;
   logic [DEPTH-1:0]   valid_ff,     valid_in;
   logic               rd_valid_ff,  rd_valid_in;
   logic [3:0]         digit_ff,     digit_in;
   logic [2:0]         ocell_ff,     ocell_in;
   logic [7:0]         obits_ff,     obits_in;
   logic               olast_ff,     olast_in;

   logic [ADDR_W-1:0]  addr;
   logic [7:0]         rd_raw;
   logic [7:0]         rd_byte;
   logic [7:0]         glyph_row;
   logic [7:0]         new_byte;
   logic               wr_en;
   logic               step_last;
   logic               step_wrap;
   logic [CELL_W-1:0]  next_cell;
   logic [2:0]         next_row;
   logic               req_accept;
   logic               in_range;

   assign addr       = {cell_ff, row_ff};
   assign rd_byte    = rd_valid_ff ? rd_raw : 8'h00;
   assign glyph_row  = FONT_ROM[gidx_ff][row_ff];
   assign req_stall  = reset || (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign in_range   = {1'b0, req_cell_index} < CELLS_W4;

   slmtb_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (new_byte),
      .rd_addr (addr),
      .rd_data (rd_raw)
   );

   // row modifier shared by the shift, glyph and OR actions
   always_comb begin
      case (act_ff)
         ACT_SHL:   new_byte = {rd_byte[6:0], carry_ff};
         ACT_SHR:   new_byte = {carry_ff, rd_byte[7:1]};
         ACT_GCOL:  new_byte = rd_byte | {7'b0, glyph_row[gcol_ff]};
         ACT_GCELL: new_byte = glyph_row << gshift_ff;
         ACT_OR:    new_byte = rd_byte | data_ff;
         default:   new_byte = rd_byte;
      endcase
   end

   // walk order over the frame entries
   always_comb begin
      step_last = 1'b1;
      step_wrap = 1'b0;
      next_cell = cell_ff;
      next_row  = row_ff;
      case (act_ff) inside
         ACT_SHL: begin
            step_last = (row_ff == 3'd7) && (cell_ff == '0);
            step_wrap = (cell_ff == '0);
            next_cell = step_wrap ? CELL_LAST : cell_ff - 1'b1;
            next_row  = step_wrap ? row_ff + 3'd1 : row_ff;
         end
         ACT_SHR: begin
            step_last = (row_ff == 3'd7) && (cell_ff == CELL_LAST);
            step_wrap = (cell_ff == CELL_LAST);
            next_cell = step_wrap ? '0 : cell_ff + 1'b1;
            next_row  = step_wrap ? row_ff + 3'd1 : row_ff;
         end
         ACT_GCOL, ACT_GCELL: begin
            step_last = (row_ff == 3'd7);
            next_row  = row_ff + 3'd1;
         end
         ACT_DISPLAY: begin
            step_last = (row_ff == 3'd7) && (cell_ff == CELL_LAST);
            next_cell = (row_ff == 3'd7) ? cell_ff + 1'b1 : cell_ff;
            next_row  = row_ff + 3'd1;
         end
         default: begin
            step_last = 1'b1;
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      gidx_in     = gidx_ff;
      gcol_in     = gcol_ff;
      gshift_in   = gshift_ff;
      data_in     = data_ff;
      cell_in     = cell_ff;
      row_in      = row_ff;
      carry_in    = carry_ff;
      valid_in    = valid_ff;
      rd_valid_in = rd_valid_ff;
      digit_in    = digit_ff;
      ocell_in    = ocell_ff;
      obits_in    = obits_ff;
      olast_in    = olast_ff;
      wr_en       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               act_in    = req_action;
               gidx_in   = glyph_index(req_char_code);
               gcol_in   = req_glyph_column;
               gshift_in = req_glyph_shift;
               data_in   = req_data_byte;
               carry_in  = 1'b0;
               row_in    = 3'd0;
               cell_in   = '0;
               case (req_action) inside
                  ACT_CLEAR: begin
                     valid_in = '0;
                  end
                  ACT_SHL, ACT_GCOL: begin
                     cell_in  = CELL_LAST;
                     state_in = ST_READ;
                  end
                  ACT_SHR, ACT_DISPLAY: begin
                     state_in = ST_READ;
                  end
                  ACT_GCELL: begin
                     cell_in = CELL_W'(req_cell_index);
                     if (in_range) begin
                        state_in = ST_READ;
                     end
                  end
                  ACT_OR: begin
                     cell_in = CELL_W'(req_cell_index);
                     row_in  = req_row_index;
                     if (in_range) begin
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_READ: begin
            rd_valid_in = valid_ff[addr];
            state_in    = ST_MOD;
         end
         ST_MOD: begin
            if (act_ff == ACT_DISPLAY) begin
               digit_in = {1'b0, row_ff} + 4'd1;
               ocell_in = 3'(cell_ff);
               obits_in = rd_byte;
               olast_in = step_last;
               state_in = ST_SEND;
            end else begin
               wr_en          = 1'b1;
               valid_in[addr] = 1'b1;
               carry_in       = (act_ff == ACT_SHL) ? rd_byte[7] : rd_byte[0];
               if (step_wrap) begin
                  carry_in = 1'b0;
               end
               if (step_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cell_in  = next_cell;
                  row_in   = next_row;
                  state_in = ST_READ;
               end
            end
         end
         ST_SEND: begin
            if (!rsp_stall) begin
               if (step_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cell_in  = next_cell;
                  row_in   = next_row;
                  state_in = ST_READ;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      act_ff      <= act_in;
      gidx_ff     <= gidx_in;
      gcol_ff     <= gcol_in;
      gshift_ff   <= gshift_in;
      data_ff     <= data_in;
      cell_ff     <= cell_in;
      row_ff      <= row_in;
      carry_ff    <= carry_in;
      rd_valid_ff <= rd_valid_in;
      digit_ff    <= digit_in;
      ocell_ff    <= ocell_in;
      obits_ff    <= obits_in;
      olast_ff    <= olast_in;
   end

   assign rsp_valid         = (state_ff == ST_SEND);
   assign rsp_out_digit     = digit_ff;
   assign rsp_out_cell      = ocell_ff;
   assign rsp_out_bits      = obits_ff;
   assign rsp_last_of_frame = olast_ff;

endmodule

`default_nettype wire

>>> design/slmtb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module slmtb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/slmtb_checker.sv
// Port-level checker for the frame buffer, bound to the top level.
`default_nettype none

`include "scrolling_led_matrix_text_buffer_unit_macros.svh"

module slmtb_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [3:0] rsp_out_digit,
   input wire logic [2:0] rsp_out_cell,
   input wire logic [7:0] rsp_out_bits,
   input wire logic       rsp_last_of_frame
);

   `SLMTB_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_out_bits) && $stable(rsp_out_digit)
         && $stable(rsp_out_cell) && $stable(rsp_last_of_frame),
      "stalled response changed")
   `SLMTB_ASSERT_NOW(a_busy_while_send, rsp_valid, req_stall,
      "request taken during display burst")
   `SLMTB_ASSERT_NOW(a_digit_range, rsp_valid,
      (rsp_out_digit != 4'd0) && (rsp_out_digit <= 4'd8), "digit out of range")
   `SLMTB_ASSERT_NOW(a_last_row, rsp_valid && rsp_last_of_frame, rsp_out_digit == 4'd8,
      "frame end not on last row")
   `SLMTB_ASSERT_NEXT(a_burst_continues, rsp_valid && !rsp_stall && !rsp_last_of_frame,
      !rsp_valid && req_stall, "display burst ended early")

endmodule

bind scrolling_led_matrix_text_buffer_unit slmtb_checker u_slmtb_checker (.*);

`default_nettype wire
